### hw/rtl/deq_pkg.sv
// Shared types, codes and default sizes for the double-ended queue.
package deq_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int DEPTH_DEFAULT      = 16;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Fixed widths of the command and result fields.
    localparam int ACTION_BITS = 3;
    localparam int FIELD_BITS  = 32;
    localparam int COUNT_BITS  = 5;
    localparam int ERROR_BITS  = 2;

    // Action codes carried by a command.
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REVERSE    = 3'd4
    } deq_action_t;

    // Error codes reported with every result.
    typedef enum logic [ERROR_BITS-1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } deq_error_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } deq_state_t;

    // One command transfer.
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [FIELD_BITS-1:0]  value;
    } deq_cmd_t;

    // One result transfer.
    typedef struct packed {
        logic [FIELD_BITS-1:0] front_value;
        logic [FIELD_BITS-1:0] back_value;
        logic [COUNT_BITS-1:0] count;
        logic                  is_empty;
        logic [ERROR_BITS-1:0] error;
    } deq_result_t;

endpackage

### hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: ring pointers, end caches and control.
//
// Usage: a command transfer takes place when start is high and busy is low; it
// carries an action (push front, push back, pop front, pop back or reverse)
// and a value used only by pushes. Every command gives exactly one result,
// shown on the result port for one cycle while done is high: the values at
// the front and back, the count, an empty flag and an error code.
// The stored values live in a ring buffer in a synchronous RAM. The values at
// both ends are also held in registers, so pushes and reverses need no read:
// their result appears the cycle after the command and a new command may be
// given every cycle. A pop that leaves the queue non-empty reads the new end
// value from the RAM, whose read data is registered, so busy is high for one
// cycle in the fill state and the result is given after that state.
// Throughput is therefore one command per cycle, except that busy holds off
// the next command after a pop that leaves values behind. A pop on an empty
// queue or a push on a full one changes nothing and reports an error.
// Reset empties the queue and clears the direction flag; the RAM is not
// cleared since an empty slot is never read. The receiver cannot stall, so
// each result must be taken in the cycle that done is high.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = deq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  deq_pkg::deq_cmd_t    cmd,
    output logic                 done,
    output deq_pkg::deq_result_t result
);

    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Physical slot that lies offs places after base around the ring.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offs);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    deq_state_t             state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   rev_reg, rev_next;
    logic                   done_reg, done_next;
    deq_error_t             err_reg, err_next;
    logic                   fill_last_reg, fill_last_next;
    logic [VALUE_BITS-1:0]  first_reg, first_next;
    logic [VALUE_BITS-1:0]  last_reg, last_next;

    logic                   accept;
    logic                   need_read;
    logic                   q_empty;
    logic                   q_full;
    logic [AW-1:0]          head_dec;
    logic [VALUE_BITS+FIELD_BITS-1:0] push_wide;
    logic [VALUE_BITS-1:0]  push_val;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_BITS-1:0]  ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_BITS-1:0]  ram_rdata;

    logic [VALUE_BITS-1:0]  front_sel, back_sel;
    logic [VALUE_BITS+FIELD_BITS-1:0] front_wide, back_wide;
    logic [CW+COUNT_BITS-1:0] count_wide;

    // Storage for the ring.
    deq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (need_read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command transfer and simple status.
    assign accept    = start && !busy;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CW'(DEPTH));
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign push_wide = {{VALUE_BITS{1'b0}}, cmd.value};
    assign push_val  = push_wide[VALUE_BITS-1:0];
    assign ram_wdata = push_val;

    // Action decode: pointer update, RAM access and end cache update.
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        err_next       = err_reg;
        fill_last_next = fill_last_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_raddr      = head_reg;
        need_read      = 1'b0;
        if (state_reg == ST_FILL)
        begin
            if (fill_last_reg)
            begin
                last_next = ram_rdata;
            end
            else
            begin
                first_next = ram_rdata;
            end
        end
        else if (accept)
        begin
            err_next = ERR_NONE;
            unique case (cmd.action)
                ACT_PUSH_FRONT, ACT_PUSH_BACK:
                begin
                    if (q_full)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        ram_we     = 1'b1;
                        if ((cmd.action == ACT_PUSH_FRONT) != rev_reg)
                        begin
                            head_next  = head_dec;
                            ram_waddr  = head_dec;
                            first_next = push_val;
                            if (q_empty)
                            begin
                                last_next = push_val;
                            end
                        end
                        else
                        begin
                            ram_waddr = ring_add(head_reg, count_reg);
                            last_next = push_val;
                            if (q_empty)
                            begin
                                first_next = push_val;
                            end
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK:
                begin
                    if (q_empty)
                    begin
                        err_next = ERR_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        need_read  = (count_reg != CW'(1));
                        if ((cmd.action == ACT_POP_FRONT) != rev_reg)
                        begin
                            head_next      = ring_add(head_reg, CW'(1));
                            ram_raddr      = head_next;
                            fill_last_next = 1'b0;
                        end
                        else
                        begin
                            ram_raddr      = ring_add(head_reg, count_reg - CW'(2));
                            fill_last_next = 1'b1;
                        end
                    end
                end
                ACT_REVERSE:
                begin
                    rev_next = ~rev_reg;
                end
                default:
                begin
                    // Unused codes leave the queue as it is.
                end
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && need_read)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        busy      = (state_reg == ST_FILL);
        done_next = (state_reg == ST_FILL) || (accept && !need_read);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            done_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            fill_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            done_reg      <= done_next;
            err_reg       <= err_next;
            fill_last_reg <= fill_last_next;
        end
    end

    // End value caches.
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    // Result formatting: the direction flag swaps the ends, an empty queue reads zero.
    assign front_sel  = q_empty ? '0 : (rev_reg ? last_reg : first_reg);
    assign back_sel   = q_empty ? '0 : (rev_reg ? first_reg : last_reg);
    assign front_wide = {{FIELD_BITS{1'b0}}, front_sel};
    assign back_wide  = {{FIELD_BITS{1'b0}}, back_sel};
    assign count_wide = {{COUNT_BITS{1'b0}}, count_reg};

    assign done               = done_reg;
    assign result.front_value = front_wide[FIELD_BITS-1:0];
    assign result.back_value  = back_wide[FIELD_BITS-1:0];
    assign result.count       = count_wide[COUNT_BITS-1:0];
    assign result.is_empty    = q_empty;
    assign result.error       = err_reg;

    // The count never exceeds the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // A refill cycle only follows an accepted pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> $past(accept && need_read))
        else $error("refill without a pop");

    // Every result follows a command or a refill.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(accept && !need_read) || $past(state_reg == ST_FILL)))
        else $error("result without a command");

    // The RAM is never written and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && need_read))
        else $error("RAM write and read overlap");

    // A full error is reported only with a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (err_reg == ERR_FULL)) |-> q_full)
        else $error("full error with room left");

endmodule

### hw/rtl/deq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered when re is high.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
